[design/discrete_output_pulse_blink_unit_macros.svh]
// Assertion macros used by the pulse and blink output core design file.
`ifndef DISCRETE_OUTPUT_PULSE_BLINK_UNIT_MACROS_SVH
`define DISCRETE_OUTPUT_PULSE_BLINK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DOPB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DOPB_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define DOPB_ASSERT(lbl, clk, rstn, prop, msg)
`define DOPB_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

[design/dopb_pkg.sv]
// Types and constants for the pulse and blink output unit.
package dopb_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_BLINK = 2'd3
  } mode_e;

  typedef struct packed {
    logic               valid;
    mode_e              mode;
    logic [VALUE_W-1:0] value;
  } stage_t;

endpackage

[design/dopb_cmd_if.sv]
// Command channel: mode and value words with valid/ready.
interface dopb_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [dopb_pkg::MODE_W-1:0]      mode;
  logic [dopb_pkg::VALUE_W-1:0]     value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

[design/dopb_res_if.sv]
// Result channel: line level and status words with valid/ready.
interface dopb_res_if;
  logic valid;
  logic ready;
  logic level;
  logic driven;
  logic pulse_active;
  logic blink_active;

  modport source (output valid, output level, output driven, output pulse_active,
                  output blink_active, input ready);
  modport sink   (input valid, input level, input driven, input pulse_active,
                  input blink_active, output ready);
endinterface

[design/dopb_cfg_if.sv]
// Configuration write channel carrying the invert_output bit.
interface dopb_cfg_if;
  logic valid;
  logic ready;
  logic invert_output;

  modport source (output valid, output invert_output, input ready);
  modport sink   (input valid, input invert_output, output ready);
endinterface

[design/dopb_in_reg.sv]
// Input register stage for command words.
module dopb_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dopb_cmd_if.sink             cmd_i,
  input  logic                 take_i,
  output dopb_pkg::stage_t     stage_o
);

  logic                         valid_q, valid_d;
  dopb_pkg::mode_e              mode_q;
  logic [dopb_pkg::VALUE_W-1:0] value_q;
  logic                         load;

  assign cmd_i.ready = !valid_q || take_i;
  assign load        = cmd_i.valid && cmd_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q  <= dopb_pkg::mode_e'(cmd_i.mode);
      value_q <= cmd_i.value;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.mode  = mode_q;
  assign stage_o.value = value_q;

endmodule

[design/dopb_core.sv]
// Line state, pulse/blink countdown and result register.
`include "discrete_output_pulse_blink_unit_macros.svh"

module dopb_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dopb_pkg::stage_t     stage_i,
  output logic                 take_o,
  dopb_cfg_if.sink             cfg_i,
  dopb_res_if.source           res_o
);

  logic                  invert_q;
  logic                  res_valid_q, res_valid_d;
  logic                  level_q, level_d;
  logic                  driven_q, driven_d;
  logic                  pulse_q, pulse_d;
  logic                  blink_q, blink_d;
  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [TIME_WIDTH-1:0] period_q, period_d;
  logic [63:0]           value_ext;
  logic [TIME_WIDTH-1:0] t;
  logic [TIME_WIDTH-1:0] rem_dec;
  logic [TIME_WIDTH-1:0] period_dec;
  logic                  rem_zero;

  assign cfg_i.ready = 1'b1;
  assign take_o      = stage_i.valid && (!res_valid_q || res_o.ready);

  assign value_ext  = {32'd0, stage_i.value};
  assign t          = value_ext[TIME_WIDTH-1:0];
  assign rem_dec    = rem_q - {{(TIME_WIDTH-1){1'b0}}, 1'b1};
  assign period_dec = period_q - {{(TIME_WIDTH-1){1'b0}}, 1'b1};
  assign rem_zero   = (rem_q == '0);

  always_comb begin
    level_d  = level_q;
    driven_d = driven_q;
    pulse_d  = pulse_q;
    blink_d  = blink_q;
    rem_d    = rem_q;
    period_d = period_q;
    if (take_o) begin
      driven_d = 1'b0;
      case (stage_i.mode)
        dopb_pkg::MODE_SET: begin
          level_d  = stage_i.value[0] ^ invert_q;
          pulse_d  = 1'b0;
          blink_d  = 1'b0;
          driven_d = 1'b1;
        end
        dopb_pkg::MODE_PULSE: begin
          level_d  = 1'b1;
          driven_d = 1'b1;
          rem_d    = t;
          pulse_d  = 1'b1;
          blink_d  = 1'b0;
        end
        dopb_pkg::MODE_BLINK: begin
          level_d  = ~level_q;
          driven_d = 1'b1;
          period_d = t;
          rem_d    = t;
          blink_d  = 1'b1;
          pulse_d  = 1'b0;
        end
        dopb_pkg::MODE_TICK: begin
          if (pulse_q) begin
            if (rem_zero) begin
              level_d  = 1'b0;
              driven_d = 1'b1;
              pulse_d  = 1'b0;
            end else begin
              rem_d = rem_dec;
            end
          end else if (blink_q) begin
            if (rem_zero) begin
              level_d  = ~level_q;
              driven_d = 1'b1;
              rem_d    = (period_q == '0) ? '0 : period_dec;
            end else begin
              rem_d = rem_dec;
            end
          end
        end
        default: begin
          driven_d = driven_q;
        end
      endcase
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (take_o) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= 1'b0;
      res_valid_q <= 1'b0;
      level_q     <= 1'b0;
      driven_q    <= 1'b0;
      pulse_q     <= 1'b0;
      blink_q     <= 1'b0;
      rem_q       <= '0;
      period_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        invert_q <= cfg_i.invert_output;
      end
      res_valid_q <= res_valid_d;
      level_q     <= level_d;
      driven_q    <= driven_d;
      pulse_q     <= pulse_d;
      blink_q     <= blink_d;
      rem_q       <= rem_d;
      period_q    <= period_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.level        = level_q;
  assign res_o.driven       = driven_q;
  assign res_o.pulse_active = pulse_q;
  assign res_o.blink_active = blink_q;

  `DOPB_NEVER(a_pulse_blink_excl, clk_i, rst_ni, pulse_q && blink_q, "pulse and blink both active")
  `DOPB_ASSERT(a_pulse_start, clk_i, rst_ni, (take_o && stage_i.mode == dopb_pkg::MODE_PULSE) |=> (level_q && driven_q && pulse_q && !blink_q), "pulse did not start high")
  `DOPB_ASSERT(a_set_cancels, clk_i, rst_ni, (take_o && stage_i.mode == dopb_pkg::MODE_SET) |=> (!pulse_q && !blink_q && driven_q && level_q == ($past(stage_i.value[0]) ^ invert_q)), "set word mishandled")
  `DOPB_ASSERT(a_idle_tick, clk_i, rst_ni, (take_o && stage_i.mode == dopb_pkg::MODE_TICK && !pulse_q && !blink_q) |=> (!driven_q && $stable(level_q)), "idle tick drove the line")
  `DOPB_ASSERT(a_stall_holds, clk_i, rst_ni, (!take_o) |=> ($stable(level_q) && $stable(rem_q) && $stable(pulse_q) && $stable(blink_q)), "state moved without a word")

endmodule

[design/discrete_output_pulse_blink_unit.sv]
// A command word is held in the input register until the core stage takes it; its result is
// then registered in the core and presented on the result port.
// Throughput: one word per cycle; a waiting result holds the core, and the input register
// takes at most one more word until that result leaves.
// The state update is one countdown decrement and compare in the core stage.
// Reset: asynchronous, active low; clears the line, pulse/blink flags, counters,
// invert_output and both valid flags.
module discrete_output_pulse_blink_unit #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dopb_cmd_if.sink    cmd_i,
  dopb_res_if.source  res_o,
  dopb_cfg_if.sink    cfg_i
);

  dopb_pkg::stage_t stage;
  logic             take;

  dopb_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .take_i  (take),
    .stage_o (stage)
  );

  dopb_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_o  (take),
    .cfg_i   (cfg_i),
    .res_o   (res_o)
  );

endmodule
